// ===== design/assert_macros.svh =====
// Assertion macros shared by the checker files.
// Depends on nothing; each macro takes a label, a clock, an active-low reset and two expressions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error("same-cycle implication violated");

// Next-cycle implication, disabled while reset is asserted.
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error("next-cycle implication violated");

`endif

// ===== design/rpa_pkg.sv =====
// Package for the RGB565 pixel ALU: opcodes, constants and the merge control struct.
// Depends on nothing.
`timescale 1ns / 1ps
package rpa_pkg;
	localparam logic [2:0] OP_LERP  = 3'd0;
	localparam logic [2:0] OP_SCALE = 3'd1;
	localparam logic [2:0] OP_ADD   = 3'd2;
	localparam logic [2:0] OP_SUB   = 3'd3;
	localparam logic [2:0] OP_HALF  = 3'd4;
	localparam logic [2:0] OP_QUANT = 3'd5;

	localparam logic [15:0] HALF_MASK = 16'hF7DE;
	// Quotient bits resolved by the lane divider, one per stage.
	localparam int unsigned DIV_STEPS = 8;

	typedef struct packed {
		logic        valid;
		logic        bypass;
		logic [15:0] color;
	} merge_ctl_t;
endpackage

// ===== design/rpa_if.sv =====
// Valid/ready channel interfaces for the RGB565 pixel ALU.
// Depends on nothing.
`timescale 1ns / 1ps
interface rpa_in_if;
	logic        valid;
	logic        ready;
	logic [2:0]  op;
	logic [15:0] color_a;
	logic [15:0] color_b;
	logic [8:0]  weight;
	logic [15:0] scale_num;
	logic [15:0] scale_den;
	logic [2:0]  red_depth;
	logic [2:0]  green_depth;
	logic [2:0]  blue_depth;
	modport source (output valid, op, color_a, color_b, weight, scale_num, scale_den,
		red_depth, green_depth, blue_depth, input ready);
	modport sink (input valid, op, color_a, color_b, weight, scale_num, scale_den,
		red_depth, green_depth, blue_depth, output ready);
endinterface

interface rpa_out_if;
	logic        valid;
	logic        ready;
	logic [15:0] color_out;
	modport source (output valid, color_out, input ready);
	modport sink (input valid, color_out, output ready);
endinterface

// ===== design/rpa_lane.sv =====
// One color channel of the pixel ALU: blend, add, subtract and a pipelined divider
// shared by scale and quantize. Depends on rpa_pkg.
`timescale 1ns / 1ps
module rpa_lane #(
	parameter int unsigned Width = 5
) (
	input  logic             clk,
	input  logic             en,
	input  logic [2:0]       op,
	input  logic [Width-1:0] chan_a,
	input  logic [Width-1:0] chan_b,
	input  logic [7:0]       weight,
	input  logic [15:0]      scale_num,
	input  logic [15:0]      scale_den,
	input  logic [2:0]       depth,
	output logic [Width-1:0] chan_out
);
	import rpa_pkg::*;

	localparam int unsigned DW = Width + 16;
	localparam int unsigned CW = DW + DIV_STEPS;
	localparam logic [Width-1:0] ChanMax = '1;

	logic [2:0]              n_c;
	logic [2:0]              qshift;
	logic [Width-1:0]        kept;
	logic [DW-1:0]           quant_num;
	logic [15:0]             quant_den;
	logic [DW-1:0]           scale_prod;
	logic signed [Width:0]   diff;
	logic signed [Width+9:0] prod;
	logic [Width:0]          sum;
	logic [Width-1:0]        simple;

	logic                    is_lerp_s1;
	logic [Width-1:0]        simple_s1;
	logic signed [Width+9:0] prod_s1;
	logic [Width-1:0]        a_s1;
	logic [Width-1:0]        lerp_res;
	logic [Width-1:0]        early0;

	logic [DW-1:0]           rem_s   [0:DIV_STEPS];
	logic [15:0]             den_s   [0:DIV_STEPS];
	logic [DIV_STEPS-1:0]    quo_s   [0:DIV_STEPS];
	logic                    div_s   [0:DIV_STEPS];
	logic [Width-1:0]        early_s [1:DIV_STEPS];

	// Quantize: clamp the depth, keep the top bits, rescale through the divider.
	always_comb begin
		n_c = depth;
		if (depth == 3'd0) begin
			n_c = 3'd1;
		end else if (depth > 3'(Width)) begin
			n_c = 3'(Width);
		end
		qshift = 3'(Width) - n_c;
		kept = chan_a >> qshift;
	end
	assign quant_num  = DW'(kept * ChanMax);
	assign quant_den  = (16'd1 << n_c) - 16'd1;
	assign scale_prod = DW'(chan_a) * DW'(scale_num);

	assign diff = $signed({1'b0, chan_b}) - $signed({1'b0, chan_a});
	assign prod = diff * $signed({1'b0, weight});

	assign sum = {1'b0, chan_a} + {1'b0, chan_b};
	always_comb begin
		case (op)
			OP_ADD:  simple = sum[Width] ? ChanMax : sum[Width-1:0];
			OP_SUB:  simple = (chan_a > chan_b) ? (chan_a - chan_b) : '0;
			default: simple = chan_a;
		endcase
	end

	always_ff @(posedge clk) begin
		if (en) begin
			is_lerp_s1 <= (op == OP_LERP);
			simple_s1  <= simple;
			prod_s1    <= prod;
			a_s1       <= chan_a;
			div_s[0]   <= (op == OP_SCALE) || (op == OP_QUANT);
			rem_s[0]   <= (op == OP_QUANT) ? quant_num : scale_prod;
			den_s[0]   <= (op == OP_QUANT) ? quant_den : scale_den;
			quo_s[0]   <= '0;
		end
	end

	// The arithmetic shift floors the scaled difference in both directions.
	assign lerp_res = Width'($signed({1'b0, a_s1}) + (prod_s1 >>> 8));
	assign early0   = is_lerp_s1 ? lerp_res : simple_s1;

	// Restoring division, most significant quotient bit first.
	for (genvar j = 1; j <= DIV_STEPS; j++) begin : g_step
		localparam int unsigned Sh = DIV_STEPS - j;
		logic [CW-1:0]    trial;
		logic             hit;
		logic [Width-1:0] early_in;
		assign trial = CW'(den_s[j-1]) << Sh;
		assign hit   = CW'(rem_s[j-1]) >= trial;
		if (j == 1) begin : g_head
			assign early_in = early0;
		end else begin : g_tail
			assign early_in = early_s[j-1];
		end
		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[j]   <= hit ? DW'(CW'(rem_s[j-1]) - trial) : rem_s[j-1];
				den_s[j]   <= den_s[j-1];
				quo_s[j]   <= quo_s[j-1] | (DIV_STEPS'(hit) << Sh);
				div_s[j]   <= div_s[j-1];
				early_s[j] <= early_in;
			end
		end
	end

	// Any quotient above the channel maximum clamps; a high bit past it means overflow.
	always_comb begin
		if (!div_s[DIV_STEPS]) begin
			chan_out = early_s[DIV_STEPS];
		end else if (quo_s[DIV_STEPS] > DIV_STEPS'(ChanMax)) begin
			chan_out = ChanMax;
		end else begin
			chan_out = quo_s[DIV_STEPS][Width-1:0];
		end
	end
endmodule

// ===== design/rpa_merge.sv =====
// Merge stage: packs the three lane results or takes the whole-pixel bypass value,
// and holds the result in the output register. Depends on rpa_pkg.
`timescale 1ns / 1ps
module rpa_merge (
	input  logic                clk,
	input  logic                arst_n,
	input  rpa_pkg::merge_ctl_t ctl,
	input  logic [4:0]          red,
	input  logic [5:0]          green,
	input  logic [4:0]          blue,
	input  logic                out_ready,
	output logic                out_valid,
	output logic [15:0]         color_out,
	output logic                advance
);
	import rpa_pkg::*;

	logic [15:0] packed_px;

	assign packed_px = ctl.bypass ? ctl.color : {red, green, blue};
	assign advance   = !out_valid || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (advance) begin
			out_valid <= ctl.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && ctl.valid) begin
			color_out <= packed_px;
		end
	end
endmodule

// ===== design/rgb565_pixel_alu_top.sv =====
// Top level of the RGB565 pixel ALU: three channel lanes, a bypass pipe and the merge stage.
// Depends on rpa_pkg, rpa_if, rpa_lane and rpa_merge.
//
//   channel   direction   payload
//   pix_in    sink        op, color_a, color_b, weight, scale_num, scale_den, depths
//   pix_out   source      color_out
//
// Every word passes through 10 registers: one after the multipliers, 8 divider stages
// (one quotient bit each) and the output register. The accepting edge loads the first,
// and the word moves on through the divider stages into the output register.
// A new word is accepted every cycle; the whole pipe advances together and halts only
// while the output register is full and not taken. Reset clears the valid bits only.
`timescale 1ns / 1ps
module rgb565_pixel_alu_top (
	input  logic   clk,
	input  logic   arst_n,
	rpa_in_if.sink    pix_in,
	rpa_out_if.source pix_out
);
	import rpa_pkg::*;

	logic        advance;
	logic        byp;
	logic [15:0] byp_color;
	logic [15:0] half_px;
	logic [4:0]  red;
	logic [5:0]  green;
	logic [4:0]  blue;

	// Valid bit and whole-pixel bypass path, aligned with the lane stages.
	logic        valid_s [0:DIV_STEPS];
	logic        byp_s   [0:DIV_STEPS];
	logic [15:0] color_s [0:DIV_STEPS];
	merge_ctl_t  ctl;

	assign pix_in.ready = advance;

	// The packed average drops the low bit of each channel before the shift,
	// so no carry crosses a channel boundary.
	assign half_px = ((pix_in.color_a & HALF_MASK) >> 1) + ((pix_in.color_b & HALF_MASK) >> 1);

	// Cases that need no per-channel work: lerp with a zero weight or one of 256 and above,
	// scale by a zero denominator, the packed average and the unused opcodes.
	always_comb begin
		byp = 1'b0;
		byp_color = pix_in.color_a;
		case (pix_in.op)
			OP_LERP: begin
				if (pix_in.weight[8]) begin
					byp = 1'b1;
					byp_color = pix_in.color_b;
				end else if (pix_in.weight == 9'd0) begin
					byp = 1'b1;
				end
			end
			OP_SCALE: byp = (pix_in.scale_den == 16'd0);
			OP_ADD,
			OP_SUB,
			OP_QUANT: byp = 1'b0;
			OP_HALF: begin
				byp = 1'b1;
				byp_color = half_px;
			end
			default: byp = 1'b1;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i <= DIV_STEPS; i++) begin
				valid_s[i] <= 1'b0;
			end
		end else if (advance) begin
			valid_s[0] <= pix_in.valid;
			for (int i = 1; i <= DIV_STEPS; i++) begin
				valid_s[i] <= valid_s[i-1];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			byp_s[0]   <= byp;
			color_s[0] <= byp_color;
			for (int i = 1; i <= DIV_STEPS; i++) begin
				byp_s[i]   <= byp_s[i-1];
				color_s[i] <= color_s[i-1];
			end
		end
	end

	rpa_lane #(.Width(5)) u_lane_r (
		.clk      (clk),
		.en       (advance),
		.op       (pix_in.op),
		.chan_a   (pix_in.color_a[15:11]),
		.chan_b   (pix_in.color_b[15:11]),
		.weight   (pix_in.weight[7:0]),
		.scale_num(pix_in.scale_num),
		.scale_den(pix_in.scale_den),
		.depth    (pix_in.red_depth),
		.chan_out (red)
	);

	rpa_lane #(.Width(6)) u_lane_g (
		.clk      (clk),
		.en       (advance),
		.op       (pix_in.op),
		.chan_a   (pix_in.color_a[10:5]),
		.chan_b   (pix_in.color_b[10:5]),
		.weight   (pix_in.weight[7:0]),
		.scale_num(pix_in.scale_num),
		.scale_den(pix_in.scale_den),
		.depth    (pix_in.green_depth),
		.chan_out (green)
	);

	rpa_lane #(.Width(5)) u_lane_b (
		.clk      (clk),
		.en       (advance),
		.op       (pix_in.op),
		.chan_a   (pix_in.color_a[4:0]),
		.chan_b   (pix_in.color_b[4:0]),
		.weight   (pix_in.weight[7:0]),
		.scale_num(pix_in.scale_num),
		.scale_den(pix_in.scale_den),
		.depth    (pix_in.blue_depth),
		.chan_out (blue)
	);

	assign ctl.valid  = valid_s[DIV_STEPS];
	assign ctl.bypass = byp_s[DIV_STEPS];
	assign ctl.color  = color_s[DIV_STEPS];

	rpa_merge u_merge (
		.clk      (clk),
		.arst_n   (arst_n),
		.ctl      (ctl),
		.red      (red),
		.green    (green),
		.blue     (blue),
		.out_ready(pix_out.ready),
		.out_valid(pix_out.valid),
		.color_out(pix_out.color_out),
		.advance  (advance)
	);
endmodule

// ===== design/rpa_checker.sv =====
// Port-level checker for the RGB565 pixel ALU, bound to the top level.
// Depends on assert_macros.svh and the top level's channel interfaces.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module rpa_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        in_ready,
	input logic        out_valid,
	input logic        out_ready,
	input logic [15:0] color_out
);
	// An empty output register must never hold off the input side.
	`ASSERT_IMPL(a_ready_when_empty, clk, arst_n, !out_valid, in_ready)
	// A word taken at the output frees the pipe in the same cycle.
	`ASSERT_IMPL(a_ready_when_taken, clk, arst_n, out_ready, in_ready)
	// The input side stalls only behind a full, untaken output register.
	`ASSERT_IMPL(a_stall_cause, clk, arst_n, !in_ready, out_valid && !out_ready)
	// A stalled result stays valid and unchanged.
	`ASSERT_NEXT(a_out_hold, clk, arst_n, out_valid && !out_ready,
		out_valid && $stable(color_out))
endmodule

bind rgb565_pixel_alu_top rpa_checker u_rpa_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.in_ready (pix_in.ready),
	.out_valid(pix_out.valid),
	.out_ready(pix_out.ready),
	.color_out(pix_out.color_out)
);

// ===== test/tb_rgb565_pixel_alu_top.sv =====
// Self-checking testbench for the RGB565 pixel ALU top level.
// Depends on rpa_pkg, rpa_if and rgb565_pixel_alu_top; a scoreboard class predicts each word.
`timescale 1ns / 1ps
module tb_rgb565_pixel_alu_top;
	import rpa_pkg::*;

	// One input word as the block sees it.
	typedef struct {
		logic [2:0]  op;
		logic [15:0] color_a;
		logic [15:0] color_b;
		logic [8:0]  weight;
		logic [15:0] scale_num;
		logic [15:0] scale_den;
		logic [2:0]  red_depth;
		logic [2:0]  green_depth;
		logic [2:0]  blue_depth;
	} pix_word_t;

	// Predicts the color of each accepted word and checks the words that come out.
	class pixel_scoreboard;
		logic [15:0] pending_colors[$];
		int unsigned mismatches;
		int unsigned checked;
		int unsigned unexpected;

		function new();
			mismatches = 0;
			checked = 0;
			unexpected = 0;
		endfunction

		static function logic [15:0] pack_rgb(int unsigned r, int unsigned g, int unsigned b);
			logic [15:0] c;
			c = {r[4:0], g[5:0], b[4:0]};
			return c;
		endfunction

		// Blend a toward b by w/256, rounding toward minus infinity.
		static function int unsigned mix_chan(int unsigned a, int unsigned b, int unsigned w);
			if (b >= a) begin
				return a + (((b - a) * w) >> 8);
			end
			return a - ((((a - b) * w) + 255) >> 8);
		endfunction

		static function int unsigned ratio_chan(int unsigned c, int unsigned num,
			int unsigned den, int unsigned cmax);
			longint unsigned v;
			v = (longint'(c) * num) / den;
			return (v > cmax) ? cmax : int'(v);
		endfunction

		static function int unsigned depth_chan(int unsigned c, int unsigned depth,
			int unsigned bits, int unsigned cmax);
			int unsigned n;
			n = depth;
			if (n < 1) n = 1;
			if (n > bits) n = bits;
			c = c >> (bits - n);
			return (c * cmax) / ((1 << n) - 1);
		endfunction

		static function logic [15:0] predict_color(pix_word_t w);
			int unsigned ar, ag, ab, br, bg, bb, r, g, b;
			logic [15:0] res;
			ar = w.color_a[15:11]; ag = w.color_a[10:5]; ab = w.color_a[4:0];
			br = w.color_b[15:11]; bg = w.color_b[10:5]; bb = w.color_b[4:0];
			res = w.color_a;
			case (w.op)
				OP_LERP: begin
					if (w.weight == 0) res = w.color_a;
					else if (w.weight >= 256) res = w.color_b;
					else res = pack_rgb(mix_chan(ar, br, w.weight), mix_chan(ag, bg, w.weight),
						mix_chan(ab, bb, w.weight));
				end
				OP_SCALE: begin
					if (w.scale_den != 0)
						res = pack_rgb(ratio_chan(ar, w.scale_num, w.scale_den, 31),
							ratio_chan(ag, w.scale_num, w.scale_den, 63),
							ratio_chan(ab, w.scale_num, w.scale_den, 31));
				end
				OP_ADD: begin
					r = ar + br; g = ag + bg; b = ab + bb;
					res = pack_rgb(r > 31 ? 31 : r, g > 63 ? 63 : g, b > 31 ? 31 : b);
				end
				OP_SUB: begin
					res = pack_rgb(ar > br ? ar - br : 0, ag > bg ? ag - bg : 0,
						ab > bb ? ab - bb : 0);
				end
				OP_HALF: res = ((w.color_a & HALF_MASK) >> 1) + ((w.color_b & HALF_MASK) >> 1);
				OP_QUANT: begin
					res = pack_rgb(depth_chan(ar, w.red_depth, 5, 31),
						depth_chan(ag, w.green_depth, 6, 63),
						depth_chan(ab, w.blue_depth, 5, 31));
				end
				default: res = w.color_a;
			endcase
			return res;
		endfunction

		function void note_input(pix_word_t w);
			pending_colors.push_back(predict_color(w));
		endfunction

		function void check_output(logic [15:0] got);
			logic [15:0] want;
			if (pending_colors.size() == 0) begin
				unexpected++;
				mismatches++;
				if (mismatches <= 10) $display("ERROR: output word %h with nothing pending", got);
				return;
			end
			want = pending_colors.pop_front();
			checked++;
			if (got !== want) begin
				mismatches++;
				if (mismatches <= 10)
					$display("ERROR: color_out mismatch, expected %h got %h", want, got);
			end
		endfunction
	endclass

	logic clk;
	logic arst_n;
	rpa_in_if  pix_in ();
	rpa_out_if pix_out ();
	pixel_scoreboard board;
	int unsigned words_sent;
	bit stimulus_done;

	rgb565_pixel_alu_top u_top (
		.clk     (clk),
		.arst_n  (arst_n),
		.pix_in  (pix_in.sink),
		.pix_out (pix_out.source)
	);

	always begin
		clk = 1'b0;
		#10;
		clk = 1'b1;
		#10;
	end

	// Output side: check every word taken at a rising edge.
	always @(posedge clk) begin
		if (arst_n && pix_out.valid && pix_out.ready) board.check_output(pix_out.color_out);
	end

	// Receiver stall pattern: random stretches of always-ready, random stalls or a toggling ready,
	// changed at the falling edge so the block samples a stable ready.
	initial begin
		int unsigned mode;
		int unsigned span;
		pix_out.ready = 1'b0;
		@(posedge arst_n);
		forever begin
			mode = $urandom_range(0, 3);
			span = $urandom_range(5, 60);
			repeat (span) begin
				@(negedge clk);
				case (mode)
					0: pix_out.ready <= 1'b1;
					1: pix_out.ready <= ($urandom_range(0, 3) != 0);
					2: pix_out.ready <= ($urandom_range(0, 3) == 0);
					default: pix_out.ready <= ~pix_out.ready;
				endcase
			end
		end
	end

	// Present one word at the falling edge and hold it until a rising edge accepts it.
	// Valid stays high when the next word follows at once.
	task automatic send_word(pix_word_t w);
		pix_in.valid       <= 1'b1;
		pix_in.op          <= w.op;
		pix_in.color_a     <= w.color_a;
		pix_in.color_b     <= w.color_b;
		pix_in.weight      <= w.weight;
		pix_in.scale_num   <= w.scale_num;
		pix_in.scale_den   <= w.scale_den;
		pix_in.red_depth   <= w.red_depth;
		pix_in.green_depth <= w.green_depth;
		pix_in.blue_depth  <= w.blue_depth;
		do @(posedge clk); while (!pix_in.ready);
		board.note_input(w);
		words_sent++;
		@(negedge clk);
	endtask

	task automatic pause_sender(int unsigned cycles);
		pix_in.valid <= 1'b0;
		repeat (cycles) @(negedge clk);
	endtask

	function automatic pix_word_t random_word();
		pix_word_t w;
		int unsigned pick;
		w.op = $urandom_range(0, 7);
		if ($urandom_range(0, 9) < 8) w.op = $urandom_range(0, 5);
		w.color_a = $urandom;
		w.color_b = $urandom;
		pick = $urandom_range(0, 9);
		// Lean on the weight endpoints and on the out-of-range values above 256.
		if (pick == 0) w.weight = 0;
		else if (pick == 1) w.weight = 256;
		else if (pick == 2) w.weight = $urandom_range(257, 511);
		else w.weight = $urandom_range(1, 255);
		// Operands either up to 512 or full 16-bit; large ratios exercise the clamp.
		if ($urandom_range(0, 1) != 0) begin
			w.scale_num = $urandom_range(0, 512);
			w.scale_den = $urandom_range(0, 512);
		end else begin
			w.scale_num = $urandom;
			w.scale_den = $urandom;
		end
		if ($urandom_range(0, 15) == 0) w.scale_den = 0;
		w.red_depth   = $urandom;
		w.green_depth = $urandom;
		w.blue_depth  = $urandom;
		return w;
	endfunction

	function automatic pix_word_t base_word(logic [2:0] op, logic [15:0] a, logic [15:0] b);
		pix_word_t w;
		w = '{op: op, color_a: a, color_b: b, weight: 9'd128, scale_num: 16'd3,
			scale_den: 16'd2, red_depth: 3'd3, green_depth: 3'd4, blue_depth: 3'd3};
		return w;
	endfunction

	initial begin
		pix_word_t w;
		int unsigned burst;
		int unsigned drain_wait;
		board = new();
		words_sent = 0;
		stimulus_done = 1'b0;
		arst_n = 1'b0;
		pix_in.valid = 1'b0;
		pix_in.op = OP_LERP;
		pix_in.color_a = '0;
		pix_in.color_b = '0;
		pix_in.weight = '0;
		pix_in.scale_num = '0;
		pix_in.scale_den = '0;
		pix_in.red_depth = '0;
		pix_in.green_depth = '0;
		pix_in.blue_depth = '0;
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// Directed words: each operation, the lerp weight limits including values past 256,
		// a zero denominator, clamped scaling, all-ones and all-zero colors, depth clamping,
		// and the two unused opcodes.
		w = base_word(OP_LERP, 16'h0000, 16'hFFFF); w.weight = 0;       send_word(w);
		w = base_word(OP_LERP, 16'h0000, 16'hFFFF); w.weight = 256;     send_word(w);
		w = base_word(OP_LERP, 16'h1234, 16'hABCD); w.weight = 9'h1FF;  send_word(w);
		w = base_word(OP_LERP, 16'hFFFF, 16'h0000); w.weight = 1;       send_word(w);
		w = base_word(OP_LERP, 16'h0000, 16'hFFFF); w.weight = 255;     send_word(w);
		w = base_word(OP_SCALE, 16'hFFFF, 0); w.scale_den = 0;          send_word(w);
		w = base_word(OP_SCALE, 16'hFFFF, 0); w.scale_num = 16'hFFFF; w.scale_den = 1;
		send_word(w);
		w = base_word(OP_SCALE, 16'hFFFF, 0); w.scale_num = 0; w.scale_den = 16'hFFFF;
		send_word(w);
		w = base_word(OP_SCALE, 16'h7BEF, 0);                           send_word(w);
		w = base_word(OP_ADD, 16'hFFFF, 16'hFFFF);                      send_word(w);
		w = base_word(OP_ADD, 16'h0841, 16'h0000);                      send_word(w);
		w = base_word(OP_SUB, 16'h0000, 16'hFFFF);                      send_word(w);
		w = base_word(OP_SUB, 16'hFFFF, 16'h0841);                      send_word(w);
		w = base_word(OP_HALF, 16'hFFFF, 16'hFFFF);                     send_word(w);
		w = base_word(OP_HALF, 16'h0821, 16'h0821);                     send_word(w);
		w = base_word(OP_QUANT, 16'hFFFF, 0);
		w.red_depth = 0; w.green_depth = 0; w.blue_depth = 0;           send_word(w);
		w = base_word(OP_QUANT, 16'hA5A5, 0);
		w.red_depth = 7; w.green_depth = 7; w.blue_depth = 7;           send_word(w);
		w = base_word(OP_QUANT, 16'h8410, 0);
		w.red_depth = 1; w.green_depth = 6; w.blue_depth = 5;           send_word(w);
		w = base_word(3'd6, 16'hBEEF, 16'h1111);                        send_word(w);
		w = base_word(3'd7, 16'h0F0F, 16'h2222);                        send_word(w);

		// Random words sent in bursts with random gaps, some stretches back to back.
		while (words_sent < 1450) begin
			burst = $urandom_range(1, 40);
			repeat (burst) send_word(random_word());
			if ($urandom_range(0, 3) != 0) pause_sender($urandom_range(1, 12));
		end
		pix_in.valid <= 1'b0;

		// Drain: wait, up to a bound, for every pending word, then let the pipe run on idle.
		drain_wait = 0;
		while (board.pending_colors.size() != 0 && drain_wait < 20000) begin
			@(posedge clk);
			drain_wait++;
		end
		repeat (40) @(posedge clk);
		stimulus_done = 1'b1;
		$display("Sent %0d words over all six operations and both unused opcodes;", words_sent);
		$display("checked %0d results, %0d mismatches, %0d unexpected, %0d still pending.",
			board.checked, board.mismatches, board.unexpected, board.pending_colors.size());
		if (board.mismatches == 0 && board.pending_colors.size() == 0) begin
			$display("== PASS ==");
		end else begin
			$display("== FAIL ==");
		end
		$finish;
	end

	// Watchdog: stops a hung run and reports it as a failure.
	initial begin
		#2_000_000;
		$display("Timeout after %0d words sent.", words_sent);
		$display("== FAIL ==");
		$finish;
	end
endmodule

// ===== filelist.f =====
+incdir+design
design/rpa_pkg.sv
design/rpa_if.sv
design/rpa_lane.sv
design/rpa_merge.sv
design/rgb565_pixel_alu_top.sv
design/rpa_checker.sv
test/tb_rgb565_pixel_alu_top.sv
